>>> hdl/tpsdg_pkg.sv
// Package for the three-phase sine DAC generator.
// Holds the field widths, the register index codes and the amplitude limit.
// No dependencies.
package tpsdg_pkg;

    localparam int ELAPSED_W = 8;
    localparam int AMP_W = 13;
    localparam int INTERVAL_W = 16;
    localparam int ACC_W = 17;
    localparam int DAC_W = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [AMP_W-1:0] AMP_FULL = 13'd4096;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_AMPLITUDE_A   = 3'd0,
        CFG_AMPLITUDE_B   = 3'd1,
        CFG_AMPLITUDE_C   = 3'd2,
        CFG_UPDATE_INTERVAL = 3'd3
    } cfg_index_t;

endpackage

>>> hdl/three_phase_sine_dac_generator_unit.sv
// Top level of the three-phase sine DAC generator.
// Accumulates elapsed time, reads a sine ROM at three phases and scales each sample.
// Depends on tpsdg_pkg.
//
//  channel | direction | ports                                 | meaning
//  s_      | in        | s_valid s_ready s_elapsed_ms          | milliseconds since last item
//  m_      | out       | m_valid m_ready m_dac_a/b/c           | one set of three DAC codes
//  cfg_    | in        | cfg_valid cfg_ready cfg_index cfg_data| register writes
//
// An item is accepted every cycle while the pipeline moves; ready follows the
// three registered stages (ROM read, multiply, code clamp and output register).
// A result passes the ROM read, product and DAC code registers after the item that causes it.
// The sine ROM is constant and needs no clearing.
// A stalled output holds the pipeline only once every stage is full.
module three_phase_sine_dac_generator_unit #(
    parameter int SAMPLES = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [tpsdg_pkg::ELAPSED_W-1:0]   s_elapsed_ms,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [tpsdg_pkg::DAC_W-1:0]       m_dac_a,
    output logic [tpsdg_pkg::DAC_W-1:0]       m_dac_b,
    output logic [tpsdg_pkg::DAC_W-1:0]       m_dac_c,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tpsdg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tpsdg_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int PW = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam logic [PW:0] SAMPLES_W = (PW + 1)'(SAMPLES);
    localparam logic [PW:0] OFFSET_B = (PW + 1)'(SAMPLES / 3);
    localparam logic [PW:0] OFFSET_C = (PW + 1)'((2 * SAMPLES) / 3);
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam int ROM_W = SAMPLES * 16;

    typedef logic signed [15:0] sine_word_t;

    function automatic sine_word_t quarter_sine(input longint unsigned t);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint signed   sum;
        longint unsigned q;
        x = (HALF_PI_Q30 * t) / SAMPLES;
        x2 = (x * x) >> 30;
        term = x;
        sum = longint'(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum = sum + longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        q = (longint'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (q > 64'd32767) begin
            q = 64'd32767;
        end
        return sine_word_t'(q[15:0]);
    endfunction

    function automatic logic [ROM_W-1:0] build_table();
        logic [ROM_W-1:0] rom;
        longint unsigned  q4;
        longint unsigned  quad;
        longint unsigned  r;
        sine_word_t       v;
        rom = '0;
        for (int k = 0; k < SAMPLES; k++) begin
            q4 = 64'(4 * k);
            quad = q4 / SAMPLES;
            r = q4 % SAMPLES;
            if (quad[0]) begin
                v = quarter_sine(SAMPLES - r);
            end else begin
                v = quarter_sine(r);
            end
            rom[k*16 +: 16] = quad[1] ? -v : v;
        end
        return rom;
    endfunction

    localparam logic [ROM_W-1:0] SINE_ROM = build_table();

    function automatic logic [tpsdg_pkg::DAC_W-1:0] clamp_code(input logic signed [29:0] p);
        logic signed [30:0] v;
        v = 31'(p) + (31'sd1 <<< 27);
        if (v[30]) begin
            return '0;
        end else if (v[30:20] > 11'd255) begin
            return 8'd255;
        end else begin
            return v[27:20];
        end
    endfunction

    logic [tpsdg_pkg::AMP_W-1:0]      amp_a_reg, amp_b_reg, amp_c_reg;
    logic [tpsdg_pkg::INTERVAL_W-1:0] interval_reg;
    logic [tpsdg_pkg::ACC_W-1:0]      acc_reg, acc_next;
    logic [PW-1:0]                    pos_reg, pos_next;
    logic [PW:0]                      idx_b_sum, idx_c_sum;
    logic [PW-1:0]                    idx_b, idx_c;
    logic [tpsdg_pkg::AMP_W-1:0]      cfg_amp_sat;
    logic                             fire;

    logic                             s1_valid_reg;
    sine_word_t                       sine_a_reg, sine_b_reg, sine_c_reg;
    logic                             s2_valid_reg;
    logic signed [29:0]               prod_a_reg, prod_b_reg, prod_c_reg;
    logic                             m_valid_reg;
    logic [tpsdg_pkg::DAC_W-1:0]      dac_a_reg, dac_b_reg, dac_c_reg;

    logic en2, en1, s_accept;

    assign en2 = !m_valid_reg || m_ready;
    assign en1 = !s2_valid_reg || en2;
    assign s_ready = !s1_valid_reg || en1;
    assign s_accept = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign cfg_amp_sat = (cfg_data[tpsdg_pkg::AMP_W-1:0] > tpsdg_pkg::AMP_FULL) ?
                         tpsdg_pkg::AMP_FULL : cfg_data[tpsdg_pkg::AMP_W-1:0];

    always_comb begin
        acc_next = acc_reg + tpsdg_pkg::ACC_W'(s_elapsed_ms);
        fire = acc_next >= tpsdg_pkg::ACC_W'(interval_reg);
        pos_next = (pos_reg == PW'(SAMPLES - 1)) ? '0 : pos_reg + 1'b1;
        idx_b_sum = {1'b0, pos_reg} + OFFSET_B;
        idx_c_sum = {1'b0, pos_reg} + OFFSET_C;
        idx_b = (idx_b_sum >= SAMPLES_W) ? PW'(idx_b_sum - SAMPLES_W) : idx_b_sum[PW-1:0];
        idx_c = (idx_c_sum >= SAMPLES_W) ? PW'(idx_c_sum - SAMPLES_W) : idx_c_sum[PW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            amp_a_reg <= '0;
            amp_b_reg <= '0;
            amp_c_reg <= '0;
            interval_reg <= tpsdg_pkg::INTERVAL_W'(1);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                tpsdg_pkg::CFG_AMPLITUDE_A:     amp_a_reg <= cfg_amp_sat;
                tpsdg_pkg::CFG_AMPLITUDE_B:     amp_b_reg <= cfg_amp_sat;
                tpsdg_pkg::CFG_AMPLITUDE_C:     amp_c_reg <= cfg_amp_sat;
                tpsdg_pkg::CFG_UPDATE_INTERVAL: interval_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            pos_reg <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                if (fire) begin
                    acc_reg <= '0;
                    pos_reg <= pos_next;
                end else begin
                    acc_reg <= acc_next;
                end
            end
            if (s_ready) begin
                s1_valid_reg <= s_accept && fire;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && fire) begin
            sine_a_reg <= SINE_ROM[{pos_reg, 4'b0000} +: 16];
            sine_b_reg <= SINE_ROM[{idx_b, 4'b0000} +: 16];
            sine_c_reg <= SINE_ROM[{idx_c, 4'b0000} +: 16];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en1) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en2) begin
                m_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1 && s1_valid_reg) begin
            prod_a_reg <= 30'(sine_a_reg * $signed({1'b0, amp_a_reg}));
            prod_b_reg <= 30'(sine_b_reg * $signed({1'b0, amp_b_reg}));
            prod_c_reg <= 30'(sine_c_reg * $signed({1'b0, amp_c_reg}));
        end
        if (en2 && s2_valid_reg) begin
            dac_a_reg <= clamp_code(prod_a_reg);
            dac_b_reg <= clamp_code(prod_b_reg);
            dac_c_reg <= clamp_code(prod_c_reg);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_dac_a = dac_a_reg;
    assign m_dac_b = dac_b_reg;
    assign m_dac_c = dac_c_reg;

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, pos_reg} < SAMPLES_W)
        else $error("Sample position left its range.");

    a_fire_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && fire) |=> (acc_reg == '0) && s1_valid_reg)
        else $error("Firing item did not clear the accumulator.");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !en1) |=> s1_valid_reg && $stable(sine_a_reg))
        else $error("Stalled ROM stage lost its item.");

    a_ready_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (s1_valid_reg && s2_valid_reg && m_valid_reg && !m_ready))
        else $error("Input blocked while the pipeline had room.");

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the three-phase sine DAC generator unit.
// Holds a driver, a monitor, a register writer and a predictor of the DAC codes.
// Depends on tpsdg_pkg and three_phase_sine_dac_generator_unit.
`timescale 1ns / 100ps

module testbench;

    localparam int SINE_POINTS = 64;
    localparam int RESET_CYCLES = 8;
    localparam int PIPE_SETTLE = 6;
    localparam int RANDOM_ITEMS = 1750;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam logic [tpsdg_pkg::ACC_W:0] ACC_MAX = 18'h1FFFF;

    typedef logic [tpsdg_pkg::ELAPSED_W-1:0] ms_t;
    typedef logic [tpsdg_pkg::CFG_DATA_W-1:0] cfg_word_t;
    typedef logic [tpsdg_pkg::CFG_INDEX_W-1:0] cfg_addr_t;
    typedef logic [tpsdg_pkg::ACC_W:0] wide_acc_t;

    typedef struct packed {
        logic [tpsdg_pkg::DAC_W-1:0] a;
        logic [tpsdg_pkg::DAC_W-1:0] b;
        logic [tpsdg_pkg::DAC_W-1:0] c;
    } dac_set_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    ms_t s_elapsed_ms = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [tpsdg_pkg::DAC_W-1:0] m_dac_a;
    logic [tpsdg_pkg::DAC_W-1:0] m_dac_b;
    logic [tpsdg_pkg::DAC_W-1:0] m_dac_c;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    cfg_addr_t cfg_index = tpsdg_pkg::CFG_AMPLITUDE_A;
    cfg_word_t cfg_data = '0;

    ms_t elapsed_backlog[$];
    dac_set_t dac_codes_due[$];

    int sine_q15[SINE_POINTS];
    logic [tpsdg_pkg::AMP_W-1:0] amp_a;
    logic [tpsdg_pkg::AMP_W-1:0] amp_b;
    logic [tpsdg_pkg::AMP_W-1:0] amp_c;
    logic [tpsdg_pkg::INTERVAL_W-1:0] interval;
    logic [tpsdg_pkg::ACC_W-1:0] ms_total;
    int sample_pos;

    bit no_idle = 1'b0;
    int gap_left = 0;
    int stall_left = 0;
    int quiet_cycles = 0;
    int failures = 0;
    int items_sent = 0;
    int results_seen = 0;
    int writes_done = 0;
    int phases_run = 0;

    three_phase_sine_dac_generator_unit #(
        .SAMPLES(SINE_POINTS)
    ) u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_elapsed_ms(s_elapsed_ms),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_dac_a(m_dac_a),
        .m_dac_b(m_dac_b),
        .m_dac_c(m_dac_c),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int quarter_wave(input int unsigned t);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned q;
        longint total;
        x = (HALF_PI_Q30 * longint'(t)) / longint'(SINE_POINTS);
        x2 = (x * x) >> 30;
        term = x;
        total = longint'(x);
        for (int n = 1; n <= 6; n++) begin
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                total -= longint'(term);
            end else begin
                total += longint'(term);
            end
        end
        if (total < 0) begin
            total = 0;
        end
        q = (longint'(total) * 32767 + (64'd1 << 29)) >> 30;
        if (q > 32767) begin
            q = 32767;
        end
        return int'(q);
    endfunction

    function automatic logic [tpsdg_pkg::DAC_W-1:0] dac_code(
        input logic [tpsdg_pkg::AMP_W-1:0] amp, input int idx);
        logic [tpsdg_pkg::AMP_W-1:0] eff;
        longint lifted;
        eff = (amp > tpsdg_pkg::AMP_FULL) ? tpsdg_pkg::AMP_FULL : amp;
        lifted = longint'(sine_q15[idx % SINE_POINTS]) * longint'({1'b0, eff})
            + (longint'(128) << 20);
        if (lifted < 0) begin
            lifted = 0;
        end
        lifted = lifted >>> 20;
        if (lifted > 255) begin
            lifted = 255;
        end
        return lifted[tpsdg_pkg::DAC_W-1:0];
    endfunction

    function automatic void advance_generator(input ms_t ms);
        wide_acc_t sum;
        dac_set_t codes;
        sum = {1'b0, ms_total} + wide_acc_t'(ms);
        if (sum > ACC_MAX) begin
            sum = ACC_MAX;
        end
        if (sum < interval) begin
            ms_total = sum[tpsdg_pkg::ACC_W-1:0];
            return;
        end
        ms_total = '0;
        codes.a = dac_code(amp_a, sample_pos);
        codes.b = dac_code(amp_b, (sample_pos + SINE_POINTS / 3) % SINE_POINTS);
        codes.c = dac_code(amp_c, (sample_pos + (2 * SINE_POINTS) / 3) % SINE_POINTS);
        dac_codes_due.push_back(codes);
        sample_pos = (sample_pos + 1) % SINE_POINTS;
    endfunction

    function automatic int idle_length();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return int'($urandom_range(1, 3));
        end
        return int'($urandom_range(8, 40));
    endfunction

    task automatic report_failure(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        failures++;
    endtask

    task automatic write_register(input cfg_addr_t idx, input cfg_word_t data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            tpsdg_pkg::CFG_AMPLITUDE_A: amp_a = data[tpsdg_pkg::AMP_W-1:0];
            tpsdg_pkg::CFG_AMPLITUDE_B: amp_b = data[tpsdg_pkg::AMP_W-1:0];
            tpsdg_pkg::CFG_AMPLITUDE_C: amp_c = data[tpsdg_pkg::AMP_W-1:0];
            tpsdg_pkg::CFG_UPDATE_INTERVAL: interval = data[tpsdg_pkg::INTERVAL_W-1:0];
            default: ;
        endcase
        writes_done++;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_idle();
        do begin
            @(posedge aclk);
            #1;
        end while (elapsed_backlog.size() != 0 || s_valid || dac_codes_due.size() != 0);
        repeat (PIPE_SETTLE) @(posedge aclk);
        phases_run++;
    endtask

    // Driver: one item offered at a time, with random gaps between items.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                advance_generator(s_elapsed_ms);
                items_sent++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (elapsed_backlog.size() != 0) begin
                    s_elapsed_ms <= elapsed_backlog.pop_front();
                    s_valid <= 1'b1;
                    gap_left = no_idle ? 0 : idle_length();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure, and every result is checked against the oldest prediction.
    always @(posedge aclk) begin
        dac_set_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (dac_codes_due.size() == 0) begin
                    report_failure($sformatf("result %0d/%0d/%0d arrived with none predicted",
                        m_dac_a, m_dac_b, m_dac_c));
                end else begin
                    want = dac_codes_due.pop_front();
                    if (m_dac_a !== want.a) begin
                        report_failure($sformatf("result %0d dac_a got %0d want %0d",
                            results_seen, m_dac_a, want.a));
                    end
                    if (m_dac_b !== want.b) begin
                        report_failure($sformatf("result %0d dac_b got %0d want %0d",
                            results_seen, m_dac_b, want.b));
                    end
                    if (m_dac_c !== want.c) begin
                        report_failure($sformatf("result %0d dac_c got %0d want %0d",
                            results_seen, m_dac_c, want.c));
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                stall_left = no_idle ? 0 : idle_length();
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles.", WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int unsigned quad;
        int unsigned rem;
        int v;
        int r;
        int count;
        int random_sent;
        cfg_word_t data;
        ms_t ms;
        ms_t first_items[3] = '{8'd0, 8'd1, 8'd255};
        ms_t burst_items[9] = '{8'd0, 8'd255, 8'd0, 8'd128, 8'd1, 8'd127,
            8'h55, 8'hAA, 8'd0};
        ms_t edge_items[6] = '{8'd255, 8'd44, 8'd1, 8'd255, 8'd45, 8'd0};

        for (int k = 0; k < SINE_POINTS; k++) begin
            quad = (4 * k) / SINE_POINTS;
            rem = (4 * k) % SINE_POINTS;
            if (quad % 2 == 1) begin
                v = quarter_wave(SINE_POINTS - rem);
            end else begin
                v = quarter_wave(rem);
            end
            sine_q15[k] = (quad >= 2) ? -v : v;
        end
        amp_a = '0;
        amp_b = '0;
        amp_c = '0;
        interval = 16'd1;
        ms_total = '0;
        sample_pos = 0;
        random_sent = 0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: zero amplitude, one millisecond per sample.
        foreach (first_items[i]) elapsed_backlog.push_back(first_items[i]);
        wait_idle();

        // Full scale, saturated amplitudes, zero interval and writes to unused indexes.
        write_register(tpsdg_pkg::CFG_AMPLITUDE_A, cfg_word_t'(tpsdg_pkg::AMP_FULL));
        write_register(tpsdg_pkg::CFG_AMPLITUDE_B, 16'hFFFF);
        write_register(tpsdg_pkg::CFG_AMPLITUDE_C, 16'h1001);
        write_register(tpsdg_pkg::CFG_UPDATE_INTERVAL, 16'd0);
        for (int i = 4; i < 8; i++) begin
            data = cfg_word_t'($urandom_range(0, 65535));
            write_register(cfg_addr_t'(i), data);
        end
        foreach (burst_items[i]) elapsed_backlog.push_back(burst_items[i]);
        wait_idle();

        // Accumulator reaching the interval exactly, with ignored upper data bits.
        write_register(tpsdg_pkg::CFG_AMPLITUDE_A, 16'd0);
        write_register(tpsdg_pkg::CFG_AMPLITUDE_B, 16'd1);
        write_register(tpsdg_pkg::CFG_AMPLITUDE_C, 16'hE800);
        write_register(tpsdg_pkg::CFG_UPDATE_INTERVAL, 16'd300);
        foreach (edge_items[i]) elapsed_backlog.push_back(edge_items[i]);
        wait_idle();

        while (random_sent < RANDOM_ITEMS) begin
            no_idle = ($urandom_range(0, 3) == 0);
            for (int ch = 0; ch < 3; ch++) begin
                r = int'($urandom_range(0, 99));
                if (r < 15) begin
                    data = '0;
                end else if (r < 30) begin
                    data = cfg_word_t'(tpsdg_pkg::AMP_FULL);
                end else if (r < 45) begin
                    data = cfg_word_t'($urandom_range(4097, 8191));
                end else begin
                    data = cfg_word_t'($urandom_range(0, 4096));
                end
                data[tpsdg_pkg::CFG_DATA_W-1:tpsdg_pkg::AMP_W] = 3'($urandom_range(0, 7));
                write_register(cfg_addr_t'(ch), data);
            end
            if (phases_run == 6) begin
                // Longest interval: 257 items of 255 ms add up to it exactly.
                write_register(tpsdg_pkg::CFG_UPDATE_INTERVAL, 16'hFFFF);
                repeat (257) elapsed_backlog.push_back(8'd255);
                random_sent += 257;
            end else begin
                r = int'($urandom_range(0, 99));
                if (r < 10) begin
                    data = 16'd0;
                end else if (r < 20) begin
                    data = 16'd1;
                end else if (r < 60) begin
                    data = cfg_word_t'($urandom_range(2, 16));
                end else if (r < 85) begin
                    data = cfg_word_t'($urandom_range(17, 400));
                end else if (r < 95) begin
                    data = cfg_word_t'($urandom_range(401, 3000));
                end else begin
                    data = cfg_word_t'($urandom_range(3001, 65535));
                end
                write_register(tpsdg_pkg::CFG_UPDATE_INTERVAL, data);
                if ($urandom_range(0, 4) == 0) begin
                    data = cfg_word_t'($urandom_range(0, 65535));
                    write_register(cfg_addr_t'($urandom_range(4, 7)), data);
                end
                count = int'($urandom_range(40, 140));
                repeat (count) begin
                    r = int'($urandom_range(0, 99));
                    if (r < 70) begin
                        ms = ms_t'($urandom_range(0, 255));
                    end else if (r < 85) begin
                        ms = ms_t'($urandom_range(0, 3));
                    end else if (r < 95) begin
                        ms = 8'd255;
                    end else begin
                        ms = 8'd0;
                    end
                    elapsed_backlog.push_back(ms);
                end
                random_sent += count;
            end
            wait_idle();
        end

        $display("Sent %0d elapsed-time items over %0d settings with %0d register writes.",
            items_sent, phases_run, writes_done);
        $display("Checked %0d sets of three-phase DAC codes; %0d mismatches.",
            results_seen, failures);
        if (failures == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
